[hw/rtl/sda_pkg.sv]
`default_nettype none

package sda_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int CORDIC_STEPS = 16;
  // Coordinates are moved up so that the top of a delta sits just below bit 59.
  localparam int PRESCALE     = 58 - COORD_WIDTH;
  localparam int XY_W         = 64;
  localparam int Z_W          = 32;
  localparam int DIR_W        = 16;
  localparam int STEP_IDX_W   = 5;

  localparam logic [Z_W-1:0]   Z_ZERO      = 32'h0000_0000;
  localparam logic [Z_W-1:0]   Z_HALF_TURN = 32'h8000_0000;
  localparam logic [Z_W-1:0]   Z_ROUND     = 32'h0000_8000;

  localparam logic [DIR_W-1:0] DIR_POS_X = 16'h0000;
  localparam logic [DIR_W-1:0] DIR_POS_Y = 16'h4000;
  localparam logic [DIR_W-1:0] DIR_NEG_X = 16'h8000;
  localparam logic [DIR_W-1:0] DIR_NEG_Y = 16'hC000;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic                   special;
    logic [DIR_W-1:0]       dir;
  } sda_stage_t;

  // atan(2^-i) / (2*pi) in Q0.32 turns.
  function automatic logic [Z_W-1:0] step_angle(input logic [STEP_IDX_W-1:0] idx);
    logic [Z_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000003;
      5'd29:   a = 32'h00000001;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/stroke_direction_angle_top.sv]
// The path from input transaction to result holds one register for the delta stage,
// one per CORDIC cell and one for the output register. Throughput: one transaction
// per cycle while out_ready is high; every stage holds one item and is refilled as
// soon as its neighbor takes it, so bubbles in the chain are absorbed.
// Reset: synchronous, active low; it clears every stage's valid flag, nothing else.
`default_nettype none

module stroke_direction_angle_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [sda_pkg::COORD_WIDTH-1:0] in_a_x,
  input  wire logic signed [sda_pkg::COORD_WIDTH-1:0] in_a_y,
  input  wire logic signed [sda_pkg::COORD_WIDTH-1:0] in_b_x,
  input  wire logic signed [sda_pkg::COORD_WIDTH-1:0] in_b_y,
  input  wire logic [sda_pkg::DIR_W-1:0]             in_fallback_dir,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [sda_pkg::DIR_W-1:0]                  out_dir_turns
);

  sda_pkg::sda_stage_t              stage_data  [sda_pkg::CORDIC_STEPS+1];
  logic [sda_pkg::CORDIC_STEPS:0]   stage_valid;
  logic [sda_pkg::CORDIC_STEPS:0]   stage_ready;

  sda_prep u_prep (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_a_x          (in_a_x),
    .in_a_y          (in_a_y),
    .in_b_x          (in_b_x),
    .in_b_y          (in_b_y),
    .in_fallback_dir (in_fallback_dir),
    .out_valid       (stage_valid[0]),
    .out_ready       (stage_ready[0]),
    .out_data        (stage_data[0])
  );

  for (genvar k = 0; k < sda_pkg::CORDIC_STEPS; k++) begin : g_cell
    sda_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_idx  (sda_pkg::STEP_IDX_W'(k)),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  sda_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (stage_valid[sda_pkg::CORDIC_STEPS]),
    .in_ready      (stage_ready[sda_pkg::CORDIC_STEPS]),
    .in_data       (stage_data[sda_pkg::CORDIC_STEPS]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_dir_turns (out_dir_turns)
  );

endmodule

`default_nettype wire

[hw/rtl/sda_prep.sv]
`default_nettype none

module sda_prep (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [sda_pkg::COORD_WIDTH-1:0] in_a_x,
  input  wire logic signed [sda_pkg::COORD_WIDTH-1:0] in_a_y,
  input  wire logic signed [sda_pkg::COORD_WIDTH-1:0] in_b_x,
  input  wire logic signed [sda_pkg::COORD_WIDTH-1:0] in_b_y,
  input  wire logic [sda_pkg::DIR_W-1:0]             in_fallback_dir,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output sda_pkg::sda_stage_t                        out_data
);

  logic signed [sda_pkg::COORD_WIDTH:0] dx;
  logic signed [sda_pkg::COORD_WIDTH:0] dy;
  logic signed [sda_pkg::COORD_WIDTH:0] x_sel;
  logic signed [sda_pkg::COORD_WIDTH:0] y_sel;
  logic signed [sda_pkg::XY_W-1:0]      x_ext;
  logic signed [sda_pkg::XY_W-1:0]      y_ext;
  logic                                 dx_zero;
  logic                                 dy_zero;
  logic                                 flip;
  sda_pkg::sda_stage_t                  data_nxt;
  sda_pkg::sda_stage_t                  data_r;
  logic                                 valid_r;

  always_comb begin
    dx      = (sda_pkg::COORD_WIDTH + 1)'(in_a_x) - (sda_pkg::COORD_WIDTH + 1)'(in_b_x);
    dy      = (sda_pkg::COORD_WIDTH + 1)'(in_a_y) - (sda_pkg::COORD_WIDTH + 1)'(in_b_y);
    dx_zero = (dx == '0);
    dy_zero = (dy == '0);
    // The CORDIC works on (-dx, dy); a positive dx puts it in the left half-plane,
    // so the vector is turned by half a turn first.
    flip    = !dx[sda_pkg::COORD_WIDTH] && !dx_zero;
    x_sel   = flip ? dx : -dx;
    y_sel   = flip ? -dy : dy;
    x_ext   = sda_pkg::XY_W'(x_sel);
    y_ext   = sda_pkg::XY_W'(y_sel);

    data_nxt.x       = x_ext <<< sda_pkg::PRESCALE;
    data_nxt.y       = y_ext <<< sda_pkg::PRESCALE;
    data_nxt.z       = flip ? sda_pkg::Z_HALF_TURN : sda_pkg::Z_ZERO;
    data_nxt.special = dx_zero || dy_zero;
    if (dx_zero && dy_zero) begin
      data_nxt.dir = in_fallback_dir;
    end else if (dx_zero) begin
      data_nxt.dir = dy[sda_pkg::COORD_WIDTH] ? sda_pkg::DIR_NEG_Y : sda_pkg::DIR_POS_Y;
    end else begin
      data_nxt.dir = dx[sda_pkg::COORD_WIDTH] ? sda_pkg::DIR_POS_X : sda_pkg::DIR_NEG_X;
    end
  end

  assign in_ready  = rst_n && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  a_coincident_fallback : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_a_x == in_b_x) && (in_a_y == in_b_y)
    |=> valid_r && data_r.special && (data_r.dir == $past(in_fallback_dir)))
    else $error("coincident points did not select the fallback direction");

  a_vertical_up : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_a_x == in_b_x) && (in_a_y > in_b_y)
    |=> valid_r && data_r.special && (data_r.dir == sda_pkg::DIR_POS_Y))
    else $error("vertical transaction with positive dy not decoded as a quarter turn");

endmodule

`default_nettype wire

[hw/rtl/sda_cell.sv]
`default_nettype none

module sda_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [sda_pkg::STEP_IDX_W-1:0]  step_idx,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sda_pkg::sda_stage_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sda_pkg::sda_stage_t                  out_data
);

  logic signed [sda_pkg::XY_W-1:0] xs;
  logic signed [sda_pkg::XY_W-1:0] ys;
  logic [sda_pkg::Z_W-1:0]         angle;
  sda_pkg::sda_stage_t             data_nxt;
  sda_pkg::sda_stage_t             data_r;
  logic                            valid_r;

  // step_idx is tied to a constant per cell, so the shifts reduce to wiring.
  always_comb begin
    xs       = in_data.x >>> step_idx;
    ys       = in_data.y >>> step_idx;
    angle    = sda_pkg::step_angle(step_idx);
    data_nxt = in_data;
    if (!in_data.y[sda_pkg::XY_W-1]) begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + angle;
    end else begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - angle;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  a_empty_takes : assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> in_ready)
    else $error("empty cell refused a transaction");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(data_r))
    else $error("stalled cell lost or changed its transaction");

endmodule

`default_nettype wire

[hw/rtl/sda_out.sv]
`default_nettype none

module sda_out (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire sda_pkg::sda_stage_t        in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [sda_pkg::DIR_W-1:0]       out_dir_turns
);

  logic [sda_pkg::Z_W-1:0]   z_round;
  logic [sda_pkg::DIR_W-1:0] dir_nxt;
  logic [sda_pkg::DIR_W-1:0] dir_r;
  logic                      valid_r;

  // Round to nearest on bit 15; a value that rounds to one turn wraps to zero.
  always_comb begin
    z_round = in_data.z + sda_pkg::Z_ROUND;
    dir_nxt = in_data.special ? in_data.dir : z_round[sda_pkg::Z_W-1 -: sda_pkg::DIR_W];
  end

  assign in_ready      = !valid_r || out_ready;
  assign out_valid     = valid_r;
  assign out_dir_turns = dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dir_r <= dir_nxt;
    end
  end

endmodule

`default_nettype wire

[tb/stroke_direction_angle_top_tb.sv]
typedef logic signed [sda_pkg::COORD_WIDTH-1:0] coord_t;
typedef logic [sda_pkg::DIR_W-1:0]              dir_t;

class direction_scoreboard;
  localparam int CW        = sda_pkg::COORD_WIDTH;
  localparam int STEPS     = sda_pkg::CORDIC_STEPS;
  // Deltas are lifted so that their top bit sits just below bit 59.
  localparam int LIFT      = 58 - CW;
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

  // atan(2^-i) / (2*pi) in Q0.32 turns.
  localparam logic [31:0] TURN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  dir_t expected_dirs[$];
  int   mismatches = 0;

  function automatic dir_t travel_direction(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                            dir_t fallback);
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] z;
    logic [31:0] rounded;
    dx = ax - bx;
    dy = ay - by;
    if (dx == 0 && dy == 0) return fallback;
    if (dx == 0) return (dy < 0) ? sda_pkg::DIR_NEG_Y : sda_pkg::DIR_POS_Y;
    if (dy == 0) return (dx < 0) ? sda_pkg::DIR_POS_X : sda_pkg::DIR_NEG_X;
    // The vector is (-dx, dy); the left half-plane is folded over by half a turn.
    x = -longint'(dx);
    y = longint'(dy);
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    x = x <<< LIFT;
    y = y <<< LIFT;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + TURN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - TURN_STEP[i];
      end
    end
    rounded = z + ROUND_HALF;
    return rounded[31:16];
  endfunction

  function void note_input(coord_t ax, coord_t ay, coord_t bx, coord_t by, dir_t fallback);
    expected_dirs.push_back(travel_direction(ax, ay, bx, by, fallback));
  endfunction

  function void check_result(dir_t got);
    dir_t want;
    if (expected_dirs.size() == 0) begin
      $error("dir_turns: expected none, actual %h", got);
      mismatches++;
      return;
    end
    want = expected_dirs.pop_front();
    if (got !== want) begin
      $error("dir_turns: expected %h, actual %h", want, got);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_dirs.size();
  endfunction
endclass

module stroke_direction_angle_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CW           = sda_pkg::COORD_WIDTH;
  localparam coord_t CMAX         = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN         = {1'b1, {(CW-1){1'b0}}};
  localparam int     LIMIT_CYCLES = 200000;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     TAIL_CYCLES  = 40;

  logic   clk             = 1'b0;
  logic   rst_n           = 1'b0;
  logic   in_valid        = 1'b0;
  logic   in_ready;
  coord_t in_a_x          = '0;
  coord_t in_a_y          = '0;
  coord_t in_b_x          = '0;
  coord_t in_b_y          = '0;
  dir_t   in_fallback_dir = '0;
  logic   out_valid;
  logic   out_ready       = 1'b0;
  dir_t   out_dir_turns;

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  logic   hold_req      = 1'b0;
  int     hold_left     = 0;
  int     cycle_count   = 0;

  direction_scoreboard sb = new();

  stroke_direction_angle_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_a_x          (in_a_x),
    .in_a_y          (in_a_y),
    .in_b_x          (in_b_x),
    .in_b_y          (in_b_y),
    .in_fallback_dir (in_fallback_dir),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dir_turns   (out_dir_turns)
  );

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check every accepted transaction, then pick the next ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_dir_turns);
    end
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(coord_t ax, coord_t ay, coord_t bx, coord_t by, dir_t fallback);
    // Each cycle is idle with the chosen percentage before the transaction is offered.
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_a_x          <= ax;
    in_a_y          <= ay;
    in_b_x          <= bx;
    in_b_y          <= by;
    in_fallback_dir <= fallback;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(ax, ay, bx, by, fallback);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic coord_t corner_coord();
    case ($urandom_range(5))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      3:       return '1;
      4:       return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic random_item();
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    dir_t   fallback;
    ax       = coord_t'($urandom);
    ay       = coord_t'($urandom);
    bx       = coord_t'($urandom);
    by       = coord_t'($urandom);
    fallback = dir_t'($urandom);
    case ($urandom_range(9))
      // Short strokes: each delta stays within -8 to 8, so points may coincide or share an axis.
      4, 5: begin
        bx = ax - coord_t'($urandom_range(16)) + coord_t'(8);
        by = ay - coord_t'($urandom_range(16)) + coord_t'(8);
      end
      6: bx = ax;
      7: by = ay;
      8: begin
        bx = ax;
        by = ay;
      end
      9: begin
        ax = corner_coord();
        ay = corner_coord();
        bx = corner_coord();
        by = corner_coord();
      end
      default: ;
    endcase
    send_item(ax, ay, bx, by, fallback);
  endtask

  initial begin
    send_idle_pct = 31;
    recv_idle_pct = 60;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Coincident points pass the fallback through.
    send_item('0, '0, '0, '0, 16'hFFFF);
    send_item(CMIN, CMAX, CMIN, CMAX, 16'h0000);
    // Pure vertical and horizontal travel.
    send_item(5, 1, 5, 0, 16'h1234);
    send_item(5, CMIN, 5, CMAX, 16'hFFFF);
    send_item(0, CMAX, 0, CMIN, 16'h0000);
    send_item(0, 7, 1, 7, 16'hFFFF);
    send_item(CMAX, 0, CMIN, 0, 16'h0000);
    send_item(CMIN, 3, CMAX, 3, 16'h5A5A);
    // One diagonal per quadrant.
    send_item(1, 1, 0, 0, 16'hFFFF);
    send_item(-1, 1, 0, 0, 16'h0000);
    send_item(-1, -1, 0, 0, 16'hFFFF);
    send_item(1, -1, 0, 0, 16'h0000);
    // Near a full turn (rounding wraps to zero), near the other axes, and diagonals.
    send_item(CMIN, -1, CMAX, 0, 16'h8001);
    send_item(CMIN, 1, CMAX, 0, 16'h7FFE);
    send_item(CMAX, 1, CMIN, 0, 16'hFFFF);
    send_item(CMAX, -1, CMIN, 0, 16'h0000);
    send_item(CMAX, CMAX, CMIN, CMIN, 16'hFFFF);
    send_item(CMIN, CMIN, CMAX, CMAX, 16'h0000);
    send_item(CMAX, CMIN, CMIN, CMAX, 16'hFFFF);
    send_item(CMIN, CMAX, CMAX, CMIN, 16'h0000);
    send_item(1, CMAX, 0, CMIN, 16'hFFFF);
    send_item(0, CMIN, 1, CMAX, 16'h0000);

    repeat (330) random_item();
    wait_drained();

    send_idle_pct = 60;
    recv_idle_pct = 31;
    repeat (330) random_item();
    // The sender pauses here until every result is back.
    wait_drained();

    // Back-to-back traffic against a long receiver hold-off fills the pipeline.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    repeat (340) random_item();

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/sda_pkg.sv
hw/rtl/sda_prep.sv
hw/rtl/sda_cell.sv
hw/rtl/sda_out.sv
hw/rtl/stroke_direction_angle_top.sv
tb/stroke_direction_angle_top_tb.sv
